@@ hw/rtl/pcbc_pkg.sv @@
// package: types and constants of the point cloud block cull
`default_nettype none
package pcbc_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_PREV  = 2'd2;
    localparam logic [1:0] OP_DELTA = 2'd3;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;

    localparam int DIV_BITS = 64;

    typedef struct packed {
        logic [1:0]         op;
        logic [11:0]        block_index;
        logic               has_delta;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         color_red;
        logic [7:0]         color_green;
        logic [7:0]         color_blue;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               from_delta;
    } out_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/pcbc_div.sv @@
// unit: restoring divider, one quotient bit a cycle
`default_nettype none
module pcbc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = 7'(pcbc_pkg::DIV_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= divisor;
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign quotient = {quo_reg[62:0], ~trial[64]};
endmodule
`default_nettype wire

@@ hw/rtl/point_cloud_block_cull_top.sv @@
// top level: point cloud block cull with removal bitmap in a block ram
// steps: a previous point with delta runs two 64-step divisions (u, v), then the
// block, read and decide states; other points go to output, marks write, clears sweep
// throughput: one request at a time; the shared radix-2 divider paces checked points
// reset: registers take their reset values and a clearing pass sweeps the map,
// all MAX_BLOCKS entries, during which no request is accepted
`default_nettype none
module point_cloud_block_cull_top #(
    parameter int TILE_PX = 16,
    parameter int MAX_BLOCKS = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pcbc_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pcbc_pkg::out_item_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIVU  = 9'b000000100,
        S_DIVV  = 9'b000001000,
        S_BLK   = 9'b000010000,
        S_ADDR  = 9'b000100000,
        S_READ  = 9'b001000000,
        S_DECIDE= 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [23:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic [12:0] fw_reg;
    logic        delta_reg;
    logic [AW:0] ptr_reg;
    pcbc_pkg::in_item_t item_reg;
    logic        out_valid_reg;
    pcbc_pkg::out_item_t out_reg;

    logic        mem [MAX_BLOCKS];
    logic        mem_q_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic        mem_wdata;
    logic [AW-1:0] rd_addr_reg;

    logic        div_start, div_done;
    logic [63:0] div_num, div_den, div_q;
    logic        neg_reg;
    logic signed [63:0] u_reg;
    logic signed [63:0] v_reg;
    logic        in_frame_reg;
    logic signed [63:0] prod_u, prod_v;
    logic [63:0] mag;
    logic        nneg;
    logic signed [63:0] num_s, q_s;
    logic [63:0] blk;
    logic        accept;
    logic        out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    pcbc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(div_den), .done(div_done), .quotient(div_q)
    );

    always_comb
    begin
        prod_u = 64'(item_reg.point_x) * $signed({40'd0, fx_reg})
               + $signed({40'd0, cx_reg}) * 64'(item_reg.point_z);
        prod_v = 64'(item_reg.point_y) * $signed({40'd0, fy_reg})
               + $signed({40'd0, cy_reg}) * 64'(item_reg.point_z);
        num_s = (state_reg == S_DIVU) ? prod_v : prod_u;
        if (state_reg == S_IDLE)
            num_s = 64'(in_data.point_x) * $signed({40'd0, fx_reg})
                  + $signed({40'd0, cx_reg}) * 64'(in_data.point_z);
        nneg = num_s[63];
        mag = nneg ? (64'd0 - num_s) : num_s;
        div_num = 2 * mag + (64'(in_data.point_z) <<< 8);
        div_den = 64'(in_data.point_z) <<< 9;
        if (state_reg != S_IDLE)
        begin
            div_num = 2 * mag + (64'(item_reg.point_z) <<< 8);
            div_den = 64'(item_reg.point_z) <<< 9;
        end
        q_s = neg_reg ? (64'd0 - div_q) : div_q;
        blk = 64'($unsigned(v_reg) / TILE_PX) * 64'(fw_reg / TILE_PX)
            + 64'($unsigned(u_reg) / TILE_PX);
    end

    always_comb
    begin
        state_next = state_reg;
        div_start = 1'b0;
        mem_we = 1'b0;
        mem_waddr = AW'(item_reg.block_index);
        mem_wdata = 1'b1;
        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = 1'b0;
                if (ptr_reg == (AW+1)'(MAX_BLOCKS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.op)
                        pcbc_pkg::OP_CLEAR: state_next = S_SWEEP;
                        pcbc_pkg::OP_MARK:  state_next = S_ADDR;
                        pcbc_pkg::OP_PREV:
                        begin
                            if (delta_reg && !in_data.point_z[31] && in_data.point_z != 0)
                            begin
                                state_next = S_DIVU;
                                div_start = 1'b1;
                            end
                            else
                                state_next = S_OUT;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_DIVU:
            begin
                if (div_done)
                begin
                    state_next = S_DIVV;
                    div_start = 1'b1;
                end
            end
            S_DIVV:
                if (div_done)
                    state_next = S_BLK;
            S_BLK:    state_next = S_READ;
            S_ADDR:
            begin
                if (item_reg.op == pcbc_pkg::OP_MARK)
                begin
                    mem_we = (32'(item_reg.block_index) < MAX_BLOCKS);
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DECIDE;
            end
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = (in_frame_reg && mem_q_reg) ? S_IDLE : S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= mem[rd_addr_reg];
        if (accept)
            item_reg <= in_data;
        if (div_start)
            neg_reg <= nneg;
        if (state_reg == S_DIVU && div_done)
            u_reg <= q_s;
        if (state_reg == S_DIVV && div_done)
            v_reg <= q_s;
        if (state_reg == S_BLK)
        begin
            in_frame_reg <= !u_reg[63] && !v_reg[63] && (u_reg < 64'(fw_reg))
                          && (blk < 64'(MAX_BLOCKS));
            rd_addr_reg <= blk[AW-1:0];
        end
        if (out_load)
        begin
            out_reg.out_x <= item_reg.point_x;
            out_reg.out_y <= item_reg.point_y;
            out_reg.out_z <= item_reg.point_z;
            out_reg.out_red <= item_reg.color_red;
            out_reg.out_green <= item_reg.color_green;
            out_reg.out_blue <= item_reg.color_blue;
            out_reg.from_delta <= (item_reg.op == pcbc_pkg::OP_DELTA);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            ptr_reg <= '0;
            delta_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fx_reg <= 24'd133120;
            fy_reg <= 24'd133120;
            cx_reg <= 24'd81920;
            cy_reg <= 24'd61440;
            fw_reg <= 13'd640;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SWEEP)
                ptr_reg <= (state_next == S_IDLE) ? '0 : ptr_reg + 1'b1;
            if (accept && in_data.op == pcbc_pkg::OP_CLEAR)
                delta_reg <= in_data.has_delta;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    pcbc_pkg::CFG_FOCAL_X:  fx_reg <= cfg_data;
                    pcbc_pkg::CFG_FOCAL_Y:  fy_reg <= cfg_data;
                    pcbc_pkg::CFG_CENTER_X: cx_reg <= cfg_data;
                    pcbc_pkg::CFG_CENTER_Y: cy_reg <= cfg_data;
                    pcbc_pkg::CFG_WIDTH:    fw_reg <= cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule
`default_nettype wire

@@ hw/rtl/pcbc_checker.sv @@
// checker: port-level assertions for the block cull top level
`default_nettype none
module pcbc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire pcbc_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire pcbc_pkg::out_item_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(in_ready) && !$isunknown(out_valid))
        else $error("handshake signal unknown");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == pcbc_pkg::OP_CLEAR |=> ##1 !$rose(out_valid))
        else $error("clear gave a result");
endmodule

bind point_cloud_block_cull_top pcbc_checker u_pcbc_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
);
`default_nettype wire

@@ test/point_cloud_block_cull_checker.sv @@
// checker: predicts kept points from requests and compares them with the output stream
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_block_cull_checker #(
    parameter int TILE_PX = 16,
    parameter int MAX_BLOCKS = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire pcbc_pkg::in_item_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire pcbc_pkg::out_item_t out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    output int                       errors,
    output int                       pending
);

    longint    focal_x, focal_y, center_x, center_y;
    longint    img_width;
    bit        removal_map [MAX_BLOCKS];
    bit        delta_present;
    pcbc_pkg::out_item_t kept_points [$];

    // pixel coordinate, rounded half away from zero
    function automatic longint pixel_of(longint c, longint z, longint f, longint ctr);
        longint num;
        longint den;
        longint mag;
        longint q;
        num = c * f + ctr * z;
        den = z * 256;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    task automatic mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        errors++;
    endtask

    task automatic apply_request(pcbc_pkg::in_item_t req);
        longint    u;
        longint    v;
        longint    blk;
        bit        drop;
        pcbc_pkg::out_item_t res;
        drop = 0;
        case (req.op)
            pcbc_pkg::OP_CLEAR:
            begin
                foreach (removal_map[i])
                    removal_map[i] = 0;
                delta_present = req.has_delta;
            end
            pcbc_pkg::OP_MARK:
            begin
                if (int'(req.block_index) < MAX_BLOCKS)
                    removal_map[req.block_index] = 1;
            end
            default:
            begin
                if (req.op == pcbc_pkg::OP_PREV && delta_present && req.point_z > 0)
                begin
                    u = pixel_of(longint'(req.point_x), longint'(req.point_z),
                                 focal_x, center_x);
                    v = pixel_of(longint'(req.point_y), longint'(req.point_z),
                                 focal_y, center_y);
                    if (u >= 0 && v >= 0 && u < img_width)
                    begin
                        blk = (v / TILE_PX) * (img_width / TILE_PX) + u / TILE_PX;
                        if (blk < MAX_BLOCKS && removal_map[blk])
                            drop = 1;
                    end
                end
                if (!drop)
                begin
                    res.out_x      = req.point_x;
                    res.out_y      = req.point_y;
                    res.out_z      = req.point_z;
                    res.out_red    = req.color_red;
                    res.out_green  = req.color_green;
                    res.out_blue   = req.color_blue;
                    res.from_delta = (req.op == pcbc_pkg::OP_DELTA);
                    kept_points.insert(kept_points.size(), res);
                end
            end
        endcase
    endtask

    task automatic check_point(pcbc_pkg::out_item_t got);
        pcbc_pkg::out_item_t want;
        if (kept_points.size() == 0)
        begin
            $display("%0t: unexpected point, expected none, got %h", $time, got);
            errors++;
        end
        else
        begin
            want = kept_points.pop_front();
            if (got.out_x !== want.out_x) mismatch("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y) mismatch("out_y", want.out_y, got.out_y);
            if (got.out_z !== want.out_z) mismatch("out_z", want.out_z, got.out_z);
            if (got.out_red !== want.out_red) mismatch("out_red", want.out_red, got.out_red);
            if (got.out_green !== want.out_green)
                mismatch("out_green", want.out_green, got.out_green);
            if (got.out_blue !== want.out_blue)
                mismatch("out_blue", want.out_blue, got.out_blue);
            if (got.from_delta !== want.from_delta)
                mismatch("from_delta", want.from_delta, got.from_delta);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x       = 133120;
            focal_y       = 133120;
            center_x      = 81920;
            center_y      = 61440;
            img_width     = 640;
            delta_present = 0;
            foreach (removal_map[i])
                removal_map[i] = 0;
            kept_points.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pcbc_pkg::CFG_FOCAL_X:  focal_x = cfg_data;
                    pcbc_pkg::CFG_FOCAL_Y:  focal_y = cfg_data;
                    pcbc_pkg::CFG_CENTER_X: center_x = cfg_data;
                    pcbc_pkg::CFG_CENTER_Y: center_y = cfg_data;
                    pcbc_pkg::CFG_WIDTH:    img_width = cfg_data[12:0];
                    default:;
                endcase
            end
            if (out_valid && out_ready)
                check_point(out_data);
            if (in_valid && in_ready)
                apply_request(in_data);
            pending = kept_points.size();
        end
    end

endmodule
`default_nettype wire

@@ test/point_cloud_block_cull_top_tb.sv @@
// testbench top: stimulus, configuration phases and verdict for the point cloud block cull
`timescale 1ns / 1ps
`default_nettype none
module point_cloud_block_cull_top_tb;

    localparam int TILE_PX = 16;
    localparam int MAX_BLOCKS = 4096;
    localparam logic [2:0] CFG_SPARE = 3'd5;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int CLEAR_WAIT = MAX_BLOCKS + 300;
    localparam int IN_BITS = $bits(pcbc_pkg::in_item_t);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pcbc_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_ready;
    pcbc_pkg::out_item_t out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors;
    int          pending;

    int unsigned focal_x, focal_y, center_x, center_y, img_width;
    int          burst_left;
    int          cycles;
    bit          hold_req;
    int          hold_count;
    int          ready_mode;
    int          mode_count;
    int          tgt_u [10];
    int          tgt_v [10];

    point_cloud_block_cull_top #(
        .TILE_PX(TILE_PX),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    point_cloud_block_cull_checker #(
        .TILE_PX(TILE_PX),
        .MAX_BLOCKS(MAX_BLOCKS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on demand
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req   = 0;
            hold_count = 800;
        end
        if (mode_count == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_count = $urandom_range(50, 400);
        end
        mode_count = mode_count - 1;
        if (hold_count > 0)
        begin
            hold_count = hold_count - 1;
            out_ready <= 1'b0;
        end
        else if (ready_mode == 0)
            out_ready <= 1'b1;
        else if (ready_mode == 1)
            out_ready <= ($urandom_range(0, 1) == 1);
        else
            out_ready <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_item(pcbc_pkg::in_item_t req);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic write_regs(int unsigned fx, int unsigned fy, int unsigned cx,
                              int unsigned cy, int unsigned w);
        logic [23:0] vals [5];
        vals = '{24'(fx), 24'(fy), 24'(cx), 24'(cy), 24'(w)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        focal_x     = fx & 24'hFFFFFF;
        focal_y     = fy & 24'hFFFFFF;
        center_x    = cx & 24'hFFFFFF;
        center_y    = cy & 24'hFFFFFF;
        img_width   = w & 13'h1FFF;
    endtask

    function automatic pcbc_pkg::in_item_t rand_req(logic [1:0] op);
        pcbc_pkg::in_item_t req;
        req             = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        req.op          = op;
        req.point_z     = $urandom_range(1 << 12, 24 << 16);
        req.point_x     = $signed($urandom_range(0, 2 * req.point_z)) - req.point_z;
        req.point_y     = $signed($urandom_range(0, 2 * req.point_z)) - req.point_z;
        return req;
    endfunction

    function automatic pcbc_pkg::in_item_t aimed_point(int k);
        pcbc_pkg::in_item_t req;
        longint   z;
        req = rand_req(pcbc_pkg::OP_PREV);
        if (focal_x != 0 && focal_y != 0)
        begin
            z = req.point_z;
            req.point_x = 32'(((longint'(tgt_u[k]) * 256 + longint'($urandom_range(0, 255))
                           - 128 - longint'(center_x)) * z) / longint'(focal_x));
            req.point_y = 32'(((longint'(tgt_v[k]) * 256 + longint'($urandom_range(0, 255))
                           - 128 - longint'(center_y)) * z) / longint'(focal_y));
        end
        return req;
    endfunction

    task automatic run_frame(bit delta, int points);
        pcbc_pkg::in_item_t req;
        int       blk;
        int       pick;
        req = rand_req(pcbc_pkg::OP_CLEAR);
        req.has_delta = delta;
        send_item(req);
        for (int k = 0; k < 10; k++)
        begin
            tgt_u[k] = $urandom_range(0, (img_width > 0) ? img_width - 1 : 0);
            tgt_v[k] = $urandom_range(0, 600);
            blk = (tgt_v[k] / TILE_PX) * (img_width / TILE_PX) + tgt_u[k] / TILE_PX;
            req = rand_req(pcbc_pkg::OP_MARK);
            if ($urandom_range(0, 7) != 0)
                req.block_index = blk[11:0];
            send_item(req);
        end
        for (int n = 0; n < points; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                req = aimed_point($urandom_range(0, 9));
            else if (pick < 14)
                req = rand_req(pcbc_pkg::OP_PREV);
            else if (pick < 17)
                req = rand_req(pcbc_pkg::OP_DELTA);
            else
            begin
                req = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
                if (req.op == pcbc_pkg::OP_CLEAR)
                    req.op = pcbc_pkg::OP_MARK;
            end
            send_item(req);
        end
    endtask

    task automatic directed();
        pcbc_pkg::in_item_t req;
        req = rand_req(pcbc_pkg::OP_CLEAR);
        req.has_delta = 1'b1;
        send_item(req);
        req = rand_req(pcbc_pkg::OP_MARK);
        req.block_index = '0;
        send_item(req);
        req.block_index = 12'hFFF;
        send_item(req);
        req.block_index = 12'd620;
        send_item(req);
        // center pixel, marked block
        req = rand_req(pcbc_pkg::OP_PREV);
        req.point_x = '0;
        req.point_y = '0;
        req.point_z = 32'sh10000;
        send_item(req);
        // depth zero and negative
        req.point_z = '0;
        send_item(req);
        req.point_z = 32'sh80000000;
        send_item(req);
        // off-frame extremes
        req = rand_req(pcbc_pkg::OP_PREV);
        req.point_x = 32'sh7FFFFFFF;
        req.point_y = 32'sh80000000;
        req.point_z = 32'sd1;
        send_item(req);
        req.point_x = 32'sh80000000;
        req.point_y = 32'sh7FFFFFFF;
        req.point_z = 32'sh7FFFFFFF;
        send_item(req);
        req = rand_req(pcbc_pkg::OP_DELTA);
        req.point_x = 32'sh80000000;
        req.point_z = 32'sh80000000;
        {req.color_red, req.color_green, req.color_blue} = 24'h000000;
        send_item(req);
        req.point_x = 32'sh7FFFFFFF;
        {req.color_red, req.color_green, req.color_blue} = 24'hFFFFFF;
        send_item(req);
        // frame without delta keeps everything
        req = rand_req(pcbc_pkg::OP_CLEAR);
        req.has_delta = 1'b0;
        send_item(req);
        req = rand_req(pcbc_pkg::OP_MARK);
        req.block_index = 12'd620;
        send_item(req);
        req = rand_req(pcbc_pkg::OP_PREV);
        req.point_x = '0;
        req.point_y = '0;
        req.point_z = 32'sh10000;
        send_item(req);
        req.op = pcbc_pkg::OP_DELTA;
        send_item(req);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        cycles     = 0;
        burst_left = 0;
        hold_req   = 0;
        hold_count = 0;
        mode_count = 0;
        ready_mode = 0;
        focal_x     = 133120;
        focal_y     = 133120;
        center_x    = 81920;
        center_y    = 61440;
        img_width   = 640;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed();
        run_frame(1, 40);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_regs($urandom_range(100, 2000) * 256, $urandom_range(100, 2000) * 256,
                              $urandom_range(0, 1024) * 256, $urandom_range(0, 600) * 256,
                              $urandom_range(16, 1024));
                1: write_regs(0, 24'hFFFFFF, 24'hFFFFFF, 0, 4096);
                2: write_regs(133120, 133120, 81920, 61440, 0);
                3: write_regs(24'hFFFFFF, 0, 0, 24'hFFFFFF, 1);
                4: write_regs($urandom, $urandom, $urandom, $urandom, 8191);
                default: write_regs(133120, 133120, 81920, 61440, 640);
            endcase
            if (phase == 4)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_SPARE;
                cfg_data  <= 24'h000010;
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            for (int f = 0; f < 4; f++)
            begin
                if (phase == 0 && f == 1)
                    hold_req = 1;
                run_frame($urandom_range(0, 4) != 0, 40);
            end
            drain();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/pcbc_pkg.sv
hw/rtl/pcbc_div.sv
hw/rtl/point_cloud_block_cull_top.sv
hw/rtl/pcbc_checker.sv
test/point_cloud_block_cull_checker.sv
test/point_cloud_block_cull_top_tb.sv
